// ----- rtl/core/mp2d_pkg.sv -----
// shared constants, types and helper functions of the 2-d max pooling unit
// no dependencies; compiled first
`timescale 1ns / 1ps

package mp2d_pkg;

	// map limits
	localparam int MAX_WIDTH    = 256;
	localparam int MAX_CHANNELS = 16;
	localparam int MAX_HEIGHT   = 1024;
	localparam int SAMPLE_BITS  = 16;
	localparam int POOL_LIMIT   = 8;

	// coordinate widths
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int CH_W  = $clog2(MAX_CHANNELS);

	// configuration register widths
	localparam int POOL_CFG_W   = 4;
	localparam int HEIGHT_CFG_W = ROW_W + 1;
	localparam int WIDTH_CFG_W  = COL_W + 1;
	localparam int CHAN_CFG_W   = CH_W + 1;
	localparam int CFG_DATA_W   = HEIGHT_CFG_W;
	localparam int CFG_IDX_W    = 3;

	// reset values of the registers and the figures derived from them
	localparam int RST_POOL_ROWS     = 2;
	localparam int RST_POOL_COLS     = 2;
	localparam int RST_IMAGE_HEIGHT  = 28;
	localparam int RST_IMAGE_WIDTH   = 28;
	localparam int RST_CHANNEL_COUNT = 1;
	localparam int RST_OUT_H = RST_IMAGE_HEIGHT / RST_POOL_ROWS;
	localparam int RST_OUT_W = (RST_IMAGE_WIDTH - RST_POOL_COLS) / RST_POOL_ROWS + 1;

	// reciprocal divide by the pool height: ceil(2^shift / p), exact for 11-bit dividends
	localparam int RECIP_SHIFT = 14;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int RECIP_ONE   = 1 << RECIP_SHIFT;
	localparam int RST_RECIP   = (RECIP_ONE + RST_POOL_ROWS - 1) / RST_POOL_ROWS;

	// running maximum store: one entry per window column and channel
	localparam int STORE_AW    = COL_W + CH_W;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_CHANNELS;

	// result queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = FIFO_AW + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POOL_ROWS     = 3'd0,
		REG_POOL_COLS     = 3'd1,
		REG_IMAGE_HEIGHT  = 3'd2,
		REG_IMAGE_WIDTH   = 3'd3,
		REG_CHANNEL_COUNT = 3'd4
	} cfg_reg_t;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		sample_t          value;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} max_entry_t;

	typedef struct packed {
		sample_t          pooled_value;
		logic [ROW_W-1:0] max_row;
		logic [COL_W-1:0] max_col;
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_col;
		logic [CH_W-1:0]  channel_index;
		logic             frame_end;
	} result_t;

	function automatic logic [RECIP_W-1:0] pool_recip(input logic [POOL_CFG_W-1:0] p);
		logic [RECIP_W-1:0] r;
		case (p)
			4'd1:    r = RECIP_W'(RECIP_ONE);
			4'd2:    r = RECIP_W'((RECIP_ONE + 1) / 2);
			4'd3:    r = RECIP_W'((RECIP_ONE + 2) / 3);
			4'd4:    r = RECIP_W'((RECIP_ONE + 3) / 4);
			4'd5:    r = RECIP_W'((RECIP_ONE + 4) / 5);
			4'd6:    r = RECIP_W'((RECIP_ONE + 5) / 6);
			4'd7:    r = RECIP_W'((RECIP_ONE + 6) / 7);
			4'd8:    r = RECIP_W'((RECIP_ONE + 7) / 8);
			default: r = RECIP_W'(RECIP_ONE);
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/core/mp2d_if.sv -----
// valid/ready channel interfaces for sample input and pooled result output
// depends on mp2d_pkg
`timescale 1ns / 1ps

interface mp2d_in_if import mp2d_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample;
	logic    frame_start;

	modport source (output valid, output sample, output frame_start, input ready);
	modport sink (input valid, input sample, input frame_start, output ready);
endinterface

interface mp2d_out_if import mp2d_pkg::*; ();
	logic             valid;
	logic             ready;
	sample_t          pooled_value;
	logic [ROW_W-1:0] max_row;
	logic [COL_W-1:0] max_col;
	logic [ROW_W-1:0] out_row;
	logic [COL_W-1:0] out_col;
	logic [CH_W-1:0]  channel_index;
	logic             frame_end;

	modport source (output valid, output pooled_value, output max_row, output max_col,
		output out_row, output out_col, output channel_index, output frame_end,
		input ready);
	modport sink (input valid, input pooled_value, input max_row, input max_col,
		input out_row, input out_col, input channel_index, input frame_end,
		output ready);
endinterface

// ----- rtl/core/mp2d_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies; read during a write to the same address returns the old data
`timescale 1ns / 1ps

module mp2d_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/mp2d_result_fifo.sv -----
// small register queue that holds finished results until the sink takes them
// depends on mp2d_pkg
`timescale 1ns / 1ps

module mp2d_result_fifo import mp2d_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  result_t            push_data,
	input  logic               pop,
	output result_t            head,
	output logic [FIFO_CW-1:0] count
);

	result_t            entries_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q;
	logic [FIFO_AW-1:0] rptr_q;
	logic [FIFO_CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + FIFO_AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + FIFO_CW'(1);
				2'b01:   count_q <= count_q - FIFO_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign head  = entries_q[rptr_q];
	assign count = count_q;

endmodule

// ----- rtl/core/max_pool_2d_argmax_stream_unit.sv -----
// streaming 2-d max pooling with argmax; one sample per cycle, back to back, while the
// result queue has free slots; a window's result passes three pipeline stages and the
// result queue before it can transfer out; throughput is one sample a cycle while ready is high, set by
// the single read-modify-write of the running maximum store with write forwarding
// reset: registers return to defaults (2x2 pool, 28x28x1 map), coordinate counters to zero;
// the running maximum store is not cleared, each window's first sample overwrites its entry
`timescale 1ns / 1ps

module max_pool_2d_argmax_stream_unit import mp2d_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	mp2d_in_if.sink               samples,
	mp2d_out_if.source            results
);

	// configuration registers
	logic [POOL_CFG_W-1:0]   pool_rows_q;
	logic [POOL_CFG_W-1:0]   pool_cols_q;
	logic [HEIGHT_CFG_W-1:0] image_height_q;
	logic [WIDTH_CFG_W-1:0]  image_width_q;
	logic [CHAN_CFG_W-1:0]   channel_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_rows_q     <= POOL_CFG_W'(RST_POOL_ROWS);
			pool_cols_q     <= POOL_CFG_W'(RST_POOL_COLS);
			image_height_q  <= HEIGHT_CFG_W'(RST_IMAGE_HEIGHT);
			image_width_q   <= WIDTH_CFG_W'(RST_IMAGE_WIDTH);
			channel_count_q <= CHAN_CFG_W'(RST_CHANNEL_COUNT);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_POOL_ROWS:     pool_rows_q     <= cfg_data[POOL_CFG_W-1:0];
				REG_POOL_COLS:     pool_cols_q     <= cfg_data[POOL_CFG_W-1:0];
				REG_IMAGE_HEIGHT:  image_height_q  <= cfg_data[HEIGHT_CFG_W-1:0];
				REG_IMAGE_WIDTH:   image_width_q   <= cfg_data[WIDTH_CFG_W-1:0];
				REG_CHANNEL_COUNT: channel_count_q <= cfg_data[CHAN_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// effective settings: out-of-range values clamp to the legal range
	logic [POOL_CFG_W-1:0]   p_eff;
	logic [POOL_CFG_W-1:0]   q_eff;
	logic [HEIGHT_CFG_W-1:0] h_eff;
	logic [WIDTH_CFG_W-1:0]  w_eff;
	logic [CHAN_CFG_W-1:0]   c_eff;

	always_comb begin
		if (pool_rows_q == '0) begin
			p_eff = POOL_CFG_W'(1);
		end else if (pool_rows_q > POOL_CFG_W'(POOL_LIMIT)) begin
			p_eff = POOL_CFG_W'(POOL_LIMIT);
		end else begin
			p_eff = pool_rows_q;
		end
		// window width never exceeds the stride
		if (pool_cols_q == '0) begin
			q_eff = POOL_CFG_W'(1);
		end else if (pool_cols_q > p_eff) begin
			q_eff = p_eff;
		end else begin
			q_eff = pool_cols_q;
		end
		if (image_height_q == '0) begin
			h_eff = HEIGHT_CFG_W'(1);
		end else if (image_height_q > HEIGHT_CFG_W'(MAX_HEIGHT)) begin
			h_eff = HEIGHT_CFG_W'(MAX_HEIGHT);
		end else begin
			h_eff = image_height_q;
		end
		if (image_width_q == '0) begin
			w_eff = WIDTH_CFG_W'(1);
		end else if (image_width_q > WIDTH_CFG_W'(MAX_WIDTH)) begin
			w_eff = WIDTH_CFG_W'(MAX_WIDTH);
		end else begin
			w_eff = image_width_q;
		end
		if (channel_count_q == '0) begin
			c_eff = CHAN_CFG_W'(1);
		end else if (channel_count_q > CHAN_CFG_W'(MAX_CHANNELS)) begin
			c_eff = CHAN_CFG_W'(MAX_CHANNELS);
		end else begin
			c_eff = channel_count_q;
		end
	end

	// derived figures, registered from the effective configuration:
	// reciprocal of the stride, and output rows / columns of full windows
	logic [RECIP_W-1:0]              recip_next;
	logic [RECIP_W-1:0]              recip_q;
	logic [HEIGHT_CFG_W+RECIP_W-1:0] oh_prod;
	logic [WIDTH_CFG_W-1:0]          w_span;
	logic [WIDTH_CFG_W+RECIP_W-1:0]  ow_prod;
	logic [WIDTH_CFG_W-1:0]          out_w_next;
	logic [HEIGHT_CFG_W-1:0]         out_h_q;
	logic [WIDTH_CFG_W-1:0]          out_w_q;

	assign recip_next = pool_recip(p_eff);
	// floor(h / p) equals (h - p) / p + 1 when h >= p, and zero otherwise
	assign oh_prod    = (HEIGHT_CFG_W+RECIP_W)'(h_eff) * (HEIGHT_CFG_W+RECIP_W)'(recip_next);
	assign w_span     = w_eff - WIDTH_CFG_W'(q_eff);
	assign ow_prod    = (WIDTH_CFG_W+RECIP_W)'(w_span) * (WIDTH_CFG_W+RECIP_W)'(recip_next);
	assign out_w_next = (w_eff >= WIDTH_CFG_W'(q_eff))
		? ow_prod[RECIP_SHIFT +: WIDTH_CFG_W] + WIDTH_CFG_W'(1) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recip_q <= RECIP_W'(RST_RECIP);
			out_h_q <= HEIGHT_CFG_W'(RST_OUT_H);
			out_w_q <= WIDTH_CFG_W'(RST_OUT_W);
		end else begin
			recip_q <= recip_next;
			out_h_q <= oh_prod[RECIP_SHIFT +: HEIGHT_CFG_W];
			out_w_q <= out_w_next;
		end
	end

	// input transfer and raster counters
	logic             in_xfer;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [CH_W-1:0]  ch_q;
	logic [ROW_W-1:0] base_row;
	logic [COL_W-1:0] base_col;
	logic [CH_W-1:0]  base_ch;
	logic             ch_wrap;
	logic             col_wrap;
	logic             row_wrap;

	assign in_xfer  = samples.valid && samples.ready;
	// frame start forces this sample to the map origin
	assign base_row = samples.frame_start ? '0 : row_q;
	assign base_col = samples.frame_start ? '0 : col_q;
	assign base_ch  = samples.frame_start ? '0 : ch_q;
	// a counter at or past its limit wraps at its next step
	assign ch_wrap  = ({1'b0, base_ch} + CHAN_CFG_W'(1)) >= c_eff;
	assign col_wrap = ({1'b0, base_col} + WIDTH_CFG_W'(1)) >= w_eff;
	assign row_wrap = ({1'b0, base_row} + HEIGHT_CFG_W'(1)) >= h_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			ch_q  <= '0;
		end else if (in_xfer) begin
			if (ch_wrap) begin
				ch_q <= '0;
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_wrap ? '0 : base_row + ROW_W'(1);
				end else begin
					col_q <= base_col + COL_W'(1);
					row_q <= base_row;
				end
			end else begin
				ch_q  <= base_ch + CH_W'(1);
				col_q <= base_col;
				row_q <= base_row;
			end
		end
	end

	// pipeline valid bits; the pipeline never stalls, the result queue absorbs backpressure
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic act_s3;
	logic in_win;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			act_s3   <= 1'b0;
		end else begin
			valid_s1 <= in_xfer;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			act_s3   <= valid_s2 && in_win;
		end
	end

	// stage 1: sample and its coordinates
	sample_t          sample_s1;
	logic [ROW_W-1:0] row_s1;
	logic [COL_W-1:0] col_s1;
	logic [CH_W-1:0]  ch_s1;

	always_ff @(posedge clk) begin
		sample_s1 <= samples.sample;
		row_s1    <= base_row;
		col_s1    <= base_col;
		ch_s1     <= base_ch;
	end

	// window row and column by reciprocal multiply
	logic [ROW_W+RECIP_W-1:0] wr_prod;
	logic [COL_W+RECIP_W-1:0] wc_prod;

	assign wr_prod = (ROW_W+RECIP_W)'(row_s1) * (ROW_W+RECIP_W)'(recip_q);
	assign wc_prod = (COL_W+RECIP_W)'(col_s1) * (COL_W+RECIP_W)'(recip_q);

	// stage 2: window coordinates, offsets inside the window, store read
	sample_t          sample_s2;
	logic [ROW_W-1:0] row_s2;
	logic [COL_W-1:0] col_s2;
	logic [CH_W-1:0]  ch_s2;
	logic [ROW_W-1:0] wr_s2;
	logic [COL_W-1:0] wc_s2;

	always_ff @(posedge clk) begin
		sample_s2 <= sample_s1;
		row_s2    <= row_s1;
		col_s2    <= col_s1;
		ch_s2     <= ch_s1;
		wr_s2     <= wr_prod[RECIP_SHIFT +: ROW_W];
		wc_s2     <= wc_prod[RECIP_SHIFT +: COL_W];
	end

	logic [ROW_W+POOL_CFG_W-1:0] wr_base;
	logic [COL_W+POOL_CFG_W-1:0] wc_base;
	logic [ROW_W-1:0]            rr;
	logic [COL_W-1:0]            cc;
	logic                        first_s2;
	logic                        last_s2;
	logic                        fend_s2;
	logic [STORE_AW-1:0]         idx_s2;

	assign wr_base = (ROW_W+POOL_CFG_W)'(wr_s2) * (ROW_W+POOL_CFG_W)'(p_eff);
	assign wc_base = (COL_W+POOL_CFG_W)'(wc_s2) * (COL_W+POOL_CFG_W)'(p_eff);
	assign rr      = row_s2 - wr_base[ROW_W-1:0];
	assign cc      = col_s2 - wc_base[COL_W-1:0];

	// only full windows count; columns past the window width inside a stride are skipped
	assign in_win = ({1'b0, row_s2} < h_eff) && ({1'b0, col_s2} < w_eff)
		&& ({1'b0, ch_s2} < c_eff) && ({1'b0, wr_s2} < out_h_q)
		&& ({1'b0, wc_s2} < out_w_q) && (cc < COL_W'(q_eff));

	assign first_s2 = (rr == '0) && (cc == '0);
	assign last_s2  = (rr == ROW_W'(p_eff) - ROW_W'(1)) && (cc == COL_W'(q_eff) - COL_W'(1));
	assign fend_s2  = ({1'b0, wr_s2} == out_h_q - HEIGHT_CFG_W'(1))
		&& ({1'b0, wc_s2} == out_w_q - WIDTH_CFG_W'(1))
		&& ({1'b0, ch_s2} == c_eff - CHAN_CFG_W'(1));
	assign idx_s2   = {wc_s2, ch_s2};

	// stage 3: compare against the stored maximum and write back
	sample_t             sample_s3;
	logic [ROW_W-1:0]    row_s3;
	logic [COL_W-1:0]    col_s3;
	logic [ROW_W-1:0]    wr_s3;
	logic [STORE_AW-1:0] idx_s3;
	logic                first_s3;
	logic                last_s3;
	logic                fend_s3;

	always_ff @(posedge clk) begin
		sample_s3 <= sample_s2;
		row_s3    <= row_s2;
		col_s3    <= col_s2;
		wr_s3     <= wr_s2;
		idx_s3    <= idx_s2;
		first_s3  <= first_s2;
		last_s3   <= last_s2;
		fend_s3   <= fend_s2;
	end

	max_entry_t rd_entry;
	max_entry_t old_entry;
	max_entry_t new_entry;
	logic       store_we;
	logic       take;

	mp2d_ram #(
		.WIDTH($bits(max_entry_t)),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (idx_s3),
		.wdata (new_entry),
		.raddr (idx_s2),
		.rdata (rd_entry)
	);

	// the write made at the edge this item's read was taken is not in the read data yet
	logic                fwd_v_q;
	logic [STORE_AW-1:0] fwd_idx_q;
	max_entry_t          fwd_data_q;
	logic                use_fwd;

	assign use_fwd   = fwd_v_q && (fwd_idx_q == idx_s3);
	assign old_entry = use_fwd ? fwd_data_q : rd_entry;
	// first sample of a window always wins; later ones only when strictly greater
	assign take      = first_s3 || (sample_s3 > old_entry.value);

	always_comb begin
		if (take) begin
			new_entry.value = sample_s3;
			new_entry.row   = row_s3;
			new_entry.col   = col_s3;
		end else begin
			new_entry = old_entry;
		end
	end

	assign store_we = act_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
		end else begin
			fwd_v_q <= store_we;
		end
	end

	always_ff @(posedge clk) begin
		fwd_idx_q  <= idx_s3;
		fwd_data_q <= new_entry;
	end

	// result on the window's last sample
	logic               res_push;
	result_t            res_data;
	result_t            head;
	logic               res_pop;
	logic [FIFO_CW-1:0] fifo_count;
	logic [FIFO_CW-1:0] reserved;

	assign res_push = act_s3 && last_s3;

	always_comb begin
		res_data.pooled_value  = new_entry.value;
		res_data.max_row       = new_entry.row;
		res_data.max_col       = new_entry.col;
		res_data.out_row       = wr_s3;
		res_data.out_col       = idx_s3[STORE_AW-1 -: COL_W];
		res_data.channel_index = idx_s3[CH_W-1:0];
		res_data.frame_end     = fend_s3;
	end

	mp2d_result_fifo u_results (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_data),
		.pop       (res_pop),
		.head      (head),
		.count     (fifo_count)
	);

	// every item in flight holds a queue slot, so a push never finds the queue full
	assign reserved = fifo_count + FIFO_CW'(valid_s1) + FIFO_CW'(valid_s2)
		+ FIFO_CW'(valid_s3);
	assign samples.ready = reserved < FIFO_CW'(FIFO_DEPTH);

	assign results.valid         = fifo_count != '0;
	assign results.pooled_value  = head.pooled_value;
	assign results.max_row       = head.max_row;
	assign results.max_col       = head.max_col;
	assign results.out_row       = head.out_row;
	assign results.out_col       = head.out_col;
	assign results.channel_index = head.channel_index;
	assign results.frame_end     = head.frame_end;
	assign res_pop               = results.valid && results.ready;

	// checks
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && !res_pop) |-> (fifo_count < FIFO_CW'(FIFO_DEPTH)))
		else $error("result queue overflow");

	a_slot_budget: assert property (@(posedge clk) disable iff (!arst_n)
		reserved <= FIFO_CW'(FIFO_DEPTH))
		else $error("more items in flight than result slots");

	a_frame_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && samples.frame_start)
		|=> (valid_s1 && row_s1 == '0 && col_s1 == '0 && ch_s1 == '0))
		else $error("frame start did not restart the coordinates");

endmodule
